// File: src/ccc_pkg.sv
// Package for the calendar clock counter: request and response payload types,
// configuration register indexes and the calendar helper functions.
// No dependencies.
package ccc_pkg;

   // Configuration register indexes
   localparam logic CSR_HOUR_24_MODE  = 1'b0;
   localparam logic CSR_COUNTING_MODE = 1'b1;

   // Request kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // Counter limits
   localparam logic [5:0]  SEC_MAX   = 6'd59;
   localparam logic [5:0]  MIN_MAX   = 6'd59;
   localparam logic [4:0]  HOUR_MAX  = 5'd23;
   localparam logic [4:0]  HOUR_NOON = 5'd12;
   localparam logic [3:0]  MONTH_MAX = 4'd12;
   localparam logic [13:0] YEAR_MAX  = 14'd9999;

   // Reset values
   localparam logic [4:0]  DAY_RESET   = 5'd1;
   localparam logic [3:0]  MONTH_RESET = 4'd1;
   localparam logic [13:0] YEAR_RESET  = 14'd2000;

   // Exact divisibility by 25: the inverse of 25 modulo 2^14, and the
   // largest product that a multiple of 25 can give
   localparam logic [13:0] INV_25     = 14'd7209;
   localparam logic [13:0] DIV_25_LIM = 14'd655;

   typedef struct packed {
      logic        kind;
      logic [4:0]  set_hour;
      logic [5:0]  set_minute;
      logic [5:0]  set_second;
      logic [4:0]  set_day;
      logic [3:0]  set_month;
      logic [13:0] set_year;
   } req_type;

   typedef struct packed {
      logic [4:0]  display_hour;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [4:0]  day_out;
      logic [3:0]  month_out;
      logic [13:0] year_out;
      logic        is_pm;
      logic        load_error;
   } rsp_type;

   // Gregorian leap year. Multiples of 100 are multiples of 4 and 25,
   // multiples of 400 are multiples of 16 and 25.
   function automatic logic leap_year(input logic [13:0] year);
      logic [13:0] prod;
      logic        div_25;
      begin
         prod   = year * INV_25;
         div_25 = (prod <= DIV_25_LIM);
         leap_year = (year[1:0] == 2'd0) && (!div_25 || (year[3:0] == 4'd0));
      end
   endfunction

   // Days in a month, zero for a month code that means nothing
   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      begin
         unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_length = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_length = 5'd30;
            4'd2:    month_length = leap ? 5'd29 : 5'd28;
            default: month_length = 5'd0;
         endcase
      end
   endfunction

endpackage

// File: src/ccc_channels.sv
// Valid/ready channel interfaces for the calendar clock counter.
// Depends on ccc_pkg for the payload types.
interface ccc_req_if;
   logic             valid;
   logic             ready;
   ccc_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ccc_rsp_if;
   logic             valid;
   logic             ready;
   ccc_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/calendar_clock_counter.sv
// Calendar clock counter top level: time and date registers, tick and load
// update, 12/24-hour display and the response register.
// Depends on ccc_pkg and the channel interfaces in ccc_channels.sv.
//
// Usage:
//   req_ch carries one request a cycle while rsp_ch does not stall: a
//   one-second tick (kind 0) or a load of a full date and time (kind 1).
//   Every request gives exactly one response on rsp_ch with the date and
//   time after the request, the PM flag and, for a rejected load, load_error.
//   The state and the response register are both written at the edge that
//   accepts the request. Throughput is one request per cycle while the
//   receiver takes each response, set by the single pass of carry and
//   date-check logic between the state registers.
//   If the receiver stalls, the response register holds its value and
//   req_ch.ready falls until the response is taken; a request is accepted in
//   the same cycle that the waiting response leaves.
//   csr_we writes hour_24_mode (index 0) or counting_mode (index 1) from bit
//   0 of csr_wdata; write them only while the block is idle.
//   Synchronous reset gives 00:00:00, 1 January 2000, 24-hour display,
//   counting off and no response pending.
module calendar_clock_counter (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic           csr_wdata,
   ccc_req_if.sink        req_ch,
   ccc_rsp_if.source      rsp_ch
);

   // Configuration
   logic hour_24_ff, hour_24_in;
   logic counting_ff, counting_in;

   // Time and date state
   logic [5:0]  sec_ff,   sec_in;
   logic [5:0]  min_ff,   min_in;
   logic [4:0]  hour_ff,  hour_in;
   logic [4:0]  day_ff,   day_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff,  year_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   ccc_pkg::rsp_type rsp_ff, rsp_in;

   logic            req_fire;
   logic [4:0]      cur_len;
   logic [4:0]      set_len;
   logic            load_ok;
   logic            load_err;
   logic [4:0]      shown_hour;
   ccc_pkg::req_type rq;

   assign rq            = req_ch.data;
   assign req_ch.ready  = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.data   = rsp_ff;

   // Configuration writes
   always_comb begin
      hour_24_in  = hour_24_ff;
      counting_in = counting_ff;
      if (csr_we) begin
         unique case (csr_index)
            ccc_pkg::CSR_HOUR_24_MODE:  hour_24_in  = csr_wdata;
            ccc_pkg::CSR_COUNTING_MODE: counting_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Month lengths for the stored date and the loaded date
   assign cur_len = ccc_pkg::month_length(month_ff, ccc_pkg::leap_year(year_ff));
   assign set_len = ccc_pkg::month_length(rq.set_month, ccc_pkg::leap_year(rq.set_year));

   // Load check: every field in range and the day inside its month
   assign load_ok = (rq.set_hour <= ccc_pkg::HOUR_MAX) && (rq.set_minute <= ccc_pkg::MIN_MAX)
                 && (rq.set_second <= ccc_pkg::SEC_MAX)
                 && (rq.set_year != 14'd0) && (rq.set_year <= ccc_pkg::YEAR_MAX)
                 && (rq.set_day != 5'd0) && (rq.set_day <= set_len);
   assign load_err = (rq.kind == ccc_pkg::KIND_LOAD) && !load_ok;

   // Next state: carry chain for a tick while counting is on, whole replacement for a good load
   always_comb begin
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      if (req_fire) begin
         if (rq.kind == ccc_pkg::KIND_LOAD) begin
            if (load_ok) begin
               sec_in   = rq.set_second;
               min_in   = rq.set_minute;
               hour_in  = rq.set_hour;
               day_in   = rq.set_day;
               month_in = rq.set_month;
               year_in  = rq.set_year;
            end
         end else if (counting_ff) begin
            if (sec_ff < ccc_pkg::SEC_MAX) begin
               sec_in = sec_ff + 6'd1;
            end else begin
               sec_in = 6'd0;
               if (min_ff < ccc_pkg::MIN_MAX) begin
                  min_in = min_ff + 6'd1;
               end else begin
                  min_in = 6'd0;
                  if (hour_ff < ccc_pkg::HOUR_MAX) begin
                     hour_in = hour_ff + 5'd1;
                  end else begin
                     hour_in = 5'd0;
                     if (day_ff < cur_len) begin
                        day_in = day_ff + 5'd1;
                     end else begin
                        day_in = 5'd1;
                        if (month_ff < ccc_pkg::MONTH_MAX) begin
                           month_in = month_ff + 4'd1;
                        end else begin
                           month_in = 4'd1;
                           year_in  = (year_ff >= ccc_pkg::YEAR_MAX) ? 14'd1
                                                                     : year_ff + 14'd1;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   // Hour as shown: 12-hour mode maps 0 to 12 and 13-23 to 1-11
   always_comb begin
      shown_hour = hour_in;
      if (!hour_24_ff) begin
         if (hour_in > ccc_pkg::HOUR_NOON) begin
            shown_hour = hour_in - ccc_pkg::HOUR_NOON;
         end else if (hour_in == 5'd0) begin
            shown_hour = ccc_pkg::HOUR_NOON;
         end
      end
   end

   // Response from the updated state
   always_comb begin
      rsp_in.display_hour = shown_hour;
      rsp_in.minute_out   = min_in;
      rsp_in.second_out   = sec_in;
      rsp_in.day_out      = day_in;
      rsp_in.month_out    = month_in;
      rsp_in.year_out     = year_in;
      rsp_in.is_pm        = (hour_in >= ccc_pkg::HOUR_NOON);
      rsp_in.load_error   = load_err;
      rsp_valid_in        = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_24_ff   <= 1'b1;
         counting_ff  <= 1'b0;
         sec_ff       <= 6'd0;
         min_ff       <= 6'd0;
         hour_ff      <= 5'd0;
         day_ff       <= ccc_pkg::DAY_RESET;
         month_ff     <= ccc_pkg::MONTH_RESET;
         year_ff      <= ccc_pkg::YEAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         hour_24_ff   <= hour_24_in;
         counting_ff  <= counting_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Stored date and time always lie in range
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      (sec_ff <= ccc_pkg::SEC_MAX) && (min_ff <= ccc_pkg::MIN_MAX)
      && (hour_ff <= ccc_pkg::HOUR_MAX) && (day_ff != 5'd0) && (day_ff <= cur_len)
      && (year_ff != 14'd0) && (year_ff <= ccc_pkg::YEAR_MAX))
      else $error("calendar state out of range");

   // A rejected load leaves the state as it was
   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && load_err) |=> ($stable(sec_ff) && $stable(min_ff) && $stable(hour_ff)
      && $stable(day_ff) && $stable(month_ff) && $stable(year_ff)))
      else $error("rejected load changed the state");

   // Every accepted request leaves a response pending, its seconds and year matching the new state
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff && (rsp_ff.second_out == sec_ff)
      && (rsp_ff.year_out == year_ff)))
      else $error("response does not follow request");

   // A tick while counting is off leaves the seconds and the day as they were
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (rq.kind == ccc_pkg::KIND_TICK) && !counting_ff)
      |=> ($stable(sec_ff) && $stable(day_ff)))
      else $error("tick moved the clock with counting off");

endmodule
